FILE: hdl/vcap_pkg.sv
package vcap_pkg;

    // Field widths of the item and result channels.
    localparam int CMD_W     = 3;
    localparam int PROD_W    = 3;
    localparam int COIN_W    = 10;
    localparam int PIN_W     = 14;
    localparam int STATUS_W  = 4;
    localparam int MONEY_W   = 11;
    localparam int STOCK_W   = 4;
    localparam int TOTAL_W   = 32;
    localparam int TRIES_W   = 2;
    localparam int PRICE_W   = 10;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;

    // Number of product slots that the price registers cover.
    localparam int MAX_SLOTS         = 5;
    localparam int PRODUCT_SLOTS_DEF = 5;

    // PIN attempts granted on each admin request.
    localparam logic [TRIES_W-1:0] PIN_TRIES = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [PRICE_W-1:0] PRICE_ONE_RST   = 10'd50;
    localparam logic [PRICE_W-1:0] PRICE_TWO_RST   = 10'd80;
    localparam logic [PRICE_W-1:0] PRICE_THREE_RST = 10'd120;
    localparam logic [PRICE_W-1:0] PRICE_FOUR_RST  = 10'd100;
    localparam logic [PRICE_W-1:0] PRICE_FIVE_RST  = 10'd70;
    localparam logic [COUNT_W-1:0] PRODUCT_CNT_RST = 3'd5;
    localparam logic [PIN_W-1:0]   ADMIN_PIN_RST   = 14'd1234;

    // Initial stock of each product slot.
    localparam logic [STOCK_W-1:0] STOCK_RESET [MAX_SLOTS] = '{
        4'd10, 4'd8, 4'd5, 4'd6, 4'd12
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRICE_ONE   = 3'd0,
        CFG_PRICE_TWO   = 3'd1,
        CFG_PRICE_THREE = 3'd2,
        CFG_PRICE_FOUR  = 3'd3,
        CFG_PRICE_FIVE  = 3'd4,
        CFG_PRODUCT_CNT = 3'd5,
        CFG_ADMIN_PIN   = 3'd6
    } cfg_index_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT   = 3'd0,
        CMD_COIN     = 3'd1,
        CMD_CANCEL   = 3'd2,
        CMD_ADMIN    = 3'd3,
        CMD_PIN      = 3'd4,
        CMD_REPORT   = 3'd5,
        CMD_EXIT     = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INVALID   = 4'd0,
        ST_SELECTED  = 4'd1,
        ST_SOLDOUT   = 4'd2,
        ST_CREDIT    = 4'd3,
        ST_DISPENSED = 4'd4,
        ST_CANCELLED = 4'd5,
        ST_PINOK     = 4'd6,
        ST_PINWRONG  = 4'd7,
        ST_DENIED    = 4'd8,
        ST_REPORT    = 4'd9,
        ST_EXIT      = 4'd10,
        ST_WRONGMODE = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SELL  = 2'd1,
        MODE_PIN   = 2'd2,
        MODE_ADMIN = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PROD_W-1:0] product;
        logic [COIN_W-1:0] coin_cents;
        logic [PIN_W-1:0]  pin_value;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [MONEY_W-1:0] money_out_cents;
        logic [MONEY_W-1:0] credit_cents;
        logic [PROD_W-1:0]  item_number;
        logic [STOCK_W-1:0] stock_left;
        logic               sold_out;
        logic [TOTAL_W-1:0] sales_total;
        logic [TRIES_W-1:0] tries_left;
    } result_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price_one;
        logic [PRICE_W-1:0] price_two;
        logic [PRICE_W-1:0] price_three;
        logic [PRICE_W-1:0] price_four;
        logic [PRICE_W-1:0] price_five;
        logic [COUNT_W-1:0] product_count;
        logic [PIN_W-1:0]   admin_pin;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [PROD_W-1:0]  chosen_item;
        logic [MONEY_W-1:0] credit;
        logic [TOTAL_W-1:0] sales_sum;
        logic [TRIES_W-1:0] attempts;
    } ctrl_t;

endpackage

FILE: hdl/vcap_if.sv
// Command item channel.
interface vcap_item_if
    import vcap_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PROD_W-1:0] product;
    logic [COIN_W-1:0] coin_cents;
    logic [PIN_W-1:0]  pin_value;

    modport source (output valid, output cmd, output product, output coin_cents,
                    output pin_value, input ready);
    modport sink   (input valid, input cmd, input product, input coin_cents,
                    input pin_value, output ready);
endinterface

// Result item channel.
interface vcap_result_if
    import vcap_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic [MONEY_W-1:0] money_out_cents;
    logic [MONEY_W-1:0] credit_cents;
    logic [PROD_W-1:0]  item_number;
    logic [STOCK_W-1:0] stock_left;
    logic               sold_out;
    logic [TOTAL_W-1:0] sales_total;
    logic [TRIES_W-1:0] tries_left;

    modport source (output valid, output status, output money_out_cents,
                    output credit_cents, output item_number, output stock_left,
                    output sold_out, output sales_total, output tries_left,
                    input ready);
    modport sink   (input valid, input status, input money_out_cents,
                    input credit_cents, input item_number, input stock_left,
                    input sold_out, input sales_total, input tries_left,
                    output ready);
endinterface

FILE: hdl/vcap_step.sv
module vcap_step
    import vcap_pkg::*;
#(
    parameter int PRODUCT_SLOTS = PRODUCT_SLOTS_DEF
)
(
    input  item_t                                   item,
    input  cfg_t                                    cfg,
    input  ctrl_t                                   ctrl,
    input  logic [PRODUCT_SLOTS-1:0][STOCK_W-1:0]   stock,
    output ctrl_t                                   ctrl_next,
    output logic [PRODUCT_SLOTS-1:0][STOCK_W-1:0]   stock_next,
    output result_t                                 res
);

    logic [COUNT_W-1:0] slots_used;
    logic               in_range;
    logic [STOCK_W-1:0] sel_stock;
    logic [STOCK_W-1:0] chosen_stock;
    logic [STOCK_W-1:0] chosen_stock_dec;
    logic [PRICE_W-1:0] chosen_price;
    logic [MONEY_W-1:0] credit_sum;
    logic               paid;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_sat;

    // Products on offer are capped by the number of slots built.
    assign slots_used = (cfg.product_count < COUNT_W'(PRODUCT_SLOTS))
                        ? cfg.product_count : COUNT_W'(PRODUCT_SLOTS);
    assign in_range   = (item.product != '0) && (item.product <= slots_used);

    // Stock lookup for the requested product and for the product being sold.
    always_comb
    begin
        sel_stock    = '0;
        chosen_stock = '0;
        for (int i = 0; i < PRODUCT_SLOTS; i++)
        begin
            if (item.product == PROD_W'(i + 1))
            begin
                sel_stock = stock[i];
            end
            if (ctrl.chosen_item == PROD_W'(i + 1))
            begin
                chosen_stock = stock[i];
            end
        end
    end

    assign chosen_stock_dec = (chosen_stock == '0) ? '0 : chosen_stock - STOCK_W'(1);

    // Price of the product being sold.
    always_comb
    begin
        case (ctrl.chosen_item)
            3'd2:    chosen_price = cfg.price_two;
            3'd3:    chosen_price = cfg.price_three;
            3'd4:    chosen_price = cfg.price_four;
            3'd5:    chosen_price = cfg.price_five;
            default: chosen_price = cfg.price_one;
        endcase
    end

    // Credit after the coin and the saturating sales total after a sale.
    assign credit_sum = ctrl.credit + MONEY_W'(item.coin_cents);
    assign paid       = credit_sum >= MONEY_W'(chosen_price);
    assign total_sum  = {1'b0, ctrl.sales_sum} + (TOTAL_W + 1)'(chosen_price);
    assign total_sat  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

    // One command: state update and result.
    always_comb
    begin
        ctrl_next  = ctrl;
        stock_next = stock;
        res        = '0;
        res.status = ST_INVALID;
        case (cmd_t'(item.cmd))
            CMD_SELECT:
            begin
                if (ctrl.mode != MODE_IDLE)
                begin
                    res.status = ST_WRONGMODE;
                end
                else if (in_range)
                begin
                    res.item_number = item.product;
                    res.stock_left  = sel_stock;
                    res.sold_out    = (sel_stock == '0);
                    if (sel_stock == '0)
                    begin
                        res.status = ST_SOLDOUT;
                    end
                    else
                    begin
                        res.status            = ST_SELECTED;
                        ctrl_next.mode        = MODE_SELL;
                        ctrl_next.chosen_item = item.product;
                        ctrl_next.credit      = '0;
                    end
                end
            end
            CMD_COIN, CMD_CANCEL:
            begin
                if (ctrl.mode != MODE_SELL)
                begin
                    res.status = ST_WRONGMODE;
                end
                else if (cmd_t'(item.cmd) == CMD_CANCEL || item.coin_cents == '0)
                begin
                    // Cancel, or a zero coin, refunds the whole credit.
                    res.status            = ST_CANCELLED;
                    res.money_out_cents   = ctrl.credit;
                    ctrl_next.credit      = '0;
                    ctrl_next.chosen_item = '0;
                    ctrl_next.mode        = MODE_IDLE;
                end
                else if (paid)
                begin
                    res.status          = ST_DISPENSED;
                    res.money_out_cents = credit_sum - MONEY_W'(chosen_price);
                    res.item_number     = ctrl.chosen_item;
                    res.stock_left      = chosen_stock_dec;
                    res.sold_out        = (chosen_stock_dec == '0);
                    for (int i = 0; i < PRODUCT_SLOTS; i++)
                    begin
                        if (ctrl.chosen_item == PROD_W'(i + 1))
                        begin
                            stock_next[i] = chosen_stock_dec;
                        end
                    end
                    ctrl_next.sales_sum   = total_sat;
                    ctrl_next.credit      = '0;
                    ctrl_next.chosen_item = '0;
                    ctrl_next.mode        = MODE_IDLE;
                end
                else
                begin
                    res.status       = ST_CREDIT;
                    res.item_number  = ctrl.chosen_item;
                    res.stock_left   = chosen_stock;
                    res.sold_out     = (chosen_stock == '0);
                    ctrl_next.credit = credit_sum;
                end
            end
            CMD_ADMIN:
            begin
                if (ctrl.mode != MODE_IDLE)
                begin
                    res.status = ST_WRONGMODE;
                end
                else
                begin
                    res.status         = ST_SELECTED;
                    res.tries_left     = PIN_TRIES;
                    ctrl_next.mode     = MODE_PIN;
                    ctrl_next.attempts = PIN_TRIES;
                end
            end
            CMD_PIN:
            begin
                if (ctrl.mode != MODE_PIN)
                begin
                    res.status = ST_WRONGMODE;
                end
                else if (item.pin_value == cfg.admin_pin)
                begin
                    res.status     = ST_PINOK;
                    res.tries_left = ctrl.attempts;
                    ctrl_next.mode = MODE_ADMIN;
                end
                else if (ctrl.attempts <= TRIES_W'(1))
                begin
                    // Last try used up: access is denied.
                    res.status         = ST_DENIED;
                    res.tries_left     = '0;
                    ctrl_next.attempts = '0;
                    ctrl_next.mode     = MODE_IDLE;
                end
                else
                begin
                    res.status         = ST_PINWRONG;
                    res.tries_left     = ctrl.attempts - TRIES_W'(1);
                    ctrl_next.attempts = ctrl.attempts - TRIES_W'(1);
                end
            end
            CMD_REPORT:
            begin
                if (ctrl.mode != MODE_ADMIN)
                begin
                    res.status = ST_WRONGMODE;
                end
                else
                begin
                    res.status      = ST_REPORT;
                    res.sales_total = ctrl.sales_sum;
                    if (in_range)
                    begin
                        res.item_number = item.product;
                        res.stock_left  = sel_stock;
                        res.sold_out    = (sel_stock == '0);
                    end
                end
            end
            CMD_EXIT:
            begin
                if (ctrl.mode != MODE_ADMIN)
                begin
                    res.status = ST_WRONGMODE;
                end
                else
                begin
                    res.status     = ST_EXIT;
                    ctrl_next.mode = MODE_IDLE;
                end
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase

        // Every result but a sale reports the credit held after the step.
        if (res.status == ST_DISPENSED)
        begin
            res.credit_cents = credit_sum;
        end
        else
        begin
            res.credit_cents = ctrl_next.credit;
        end
    end

endmodule

FILE: hdl/vending_controller_with_admin_pin_core.sv
// Vending controller with administrator PIN access.
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless results stall; the command step is combinational.
// Results wait in the result register while the next item is already taken in.
// Reset (rst_n low, asynchronous): idle mode, no credit, initial stock and prices,
// zero sales total, three PIN attempts, both channels empty.
module vending_controller_with_admin_pin_core
    import vcap_pkg::*;
#(
    parameter int PRODUCT_SLOTS = PRODUCT_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    vcap_item_if.sink            items,
    vcap_result_if.source        results
);

    cfg_t                                  cfg_reg;
    ctrl_t                                 ctrl_reg;
    ctrl_t                                 ctrl_next;
    logic [PRODUCT_SLOTS-1:0][STOCK_W-1:0] stock_reg;
    logic [PRODUCT_SLOTS-1:0][STOCK_W-1:0] stock_next;
    logic                                  in_valid_reg;
    item_t                                 in_item_reg;
    logic                                  out_valid_reg;
    result_t                               out_res_reg;
    result_t                               res_next;
    logic                                  out_free;
    logic                                  step_fire;

    // Handshake: the result register frees when empty or being taken.
    assign out_free    = !out_valid_reg || results.ready;
    assign step_fire   = in_valid_reg && out_free;
    assign items.ready = !in_valid_reg || out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.price_one     <= PRICE_ONE_RST;
            cfg_reg.price_two     <= PRICE_TWO_RST;
            cfg_reg.price_three   <= PRICE_THREE_RST;
            cfg_reg.price_four    <= PRICE_FOUR_RST;
            cfg_reg.price_five    <= PRICE_FIVE_RST;
            cfg_reg.product_count <= PRODUCT_CNT_RST;
            cfg_reg.admin_pin     <= ADMIN_PIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PRICE_ONE:   cfg_reg.price_one     <= cfg_data[PRICE_W-1:0];
                CFG_PRICE_TWO:   cfg_reg.price_two     <= cfg_data[PRICE_W-1:0];
                CFG_PRICE_THREE: cfg_reg.price_three   <= cfg_data[PRICE_W-1:0];
                CFG_PRICE_FOUR:  cfg_reg.price_four    <= cfg_data[PRICE_W-1:0];
                CFG_PRICE_FIVE:  cfg_reg.price_five    <= cfg_data[PRICE_W-1:0];
                CFG_PRODUCT_CNT: cfg_reg.product_count <= cfg_data[COUNT_W-1:0];
                CFG_ADMIN_PIN:   cfg_reg.admin_pin     <= cfg_data[PIN_W-1:0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            in_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            in_item_reg.cmd        <= items.cmd;
            in_item_reg.product    <= items.product;
            in_item_reg.coin_cents <= items.coin_cents;
            in_item_reg.pin_value  <= items.pin_value;
        end
    end

    // Command step logic.
    vcap_step #(
        .PRODUCT_SLOTS (PRODUCT_SLOTS)
    ) u_step (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .ctrl       (ctrl_reg),
        .stock      (stock_reg),
        .ctrl_next  (ctrl_next),
        .stock_next (stock_next),
        .res        (res_next)
    );

    // Controller state and stock, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode        <= MODE_IDLE;
            ctrl_reg.chosen_item <= '0;
            ctrl_reg.credit      <= '0;
            ctrl_reg.sales_sum   <= '0;
            ctrl_reg.attempts    <= PIN_TRIES;
            for (int i = 0; i < PRODUCT_SLOTS; i++)
            begin
                stock_reg[i] <= STOCK_RESET[i];
            end
        end
        else if (step_fire)
        begin
            ctrl_reg  <= ctrl_next;
            stock_reg <= stock_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_res_reg <= res_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.status          = out_res_reg.status;
    assign results.money_out_cents = out_res_reg.money_out_cents;
    assign results.credit_cents    = out_res_reg.credit_cents;
    assign results.item_number     = out_res_reg.item_number;
    assign results.stock_left      = out_res_reg.stock_left;
    assign results.sold_out        = out_res_reg.sold_out;
    assign results.sales_total     = out_res_reg.sales_total;
    assign results.tries_left      = out_res_reg.tries_left;

endmodule
